[rtl/vfc_pkg.sv]
// Shared types, codes and helpers for the view frustum culling block.
`default_nettype none

package vfc_pkg;

    localparam int PLANES      = 6;
    localparam int DATA_W      = 32;
    localparam int MAG_W       = 33;
    localparam int OPD_W       = 33;
    localparam int PROD_W      = 66;
    localparam int ACC_W       = 68;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = 32;
    localparam int TDATA_IN_W  = 232;
    localparam int TUSER_W     = 3;
    localparam int TDATA_OUT_W = 8;

    // Operation codes carried in tuser
    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_POINT   = 3'd1;
    localparam logic [2:0] OP_SPHERE  = 3'd2;
    localparam logic [2:0] OP_BOX     = 3'd3;
    localparam logic [2:0] OP_VISIBLE = 3'd4;

    // Containment codes
    localparam logic [1:0] CONT_INSIDE  = 2'd0;
    localparam logic [1:0] CONT_ISECT   = 2'd1;
    localparam logic [1:0] CONT_OUTSIDE = 2'd2;

    localparam logic [1:0] ROW_LAST   = 2'd3;
    localparam logic [1:0] AXIS_CONST = 2'd3;
    localparam logic [1:0] AXIS_Z     = 2'd2;
    localparam logic [2:0] PLANE_LAST = 3'(PLANES - 1);

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic       capture;
        logic       row_wr;
        logic       raw;
        logic       sq_mul;
        logic       acc_clr;
        logic       acc_add;
        logic       sqrt_go;
        logic       div_go;
        logic       plane_wr;
        logic       q_init;
        logic       const_ld;
        logic       q_mul;
        logic       q_eval;
        logic       push;
        logic [2:0] plane;
        logic [1:0] axis;
    } vfc_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] row;
        logic       sqrt_busy;
        logic       div_busy;
        logic       out_full;
    } vfc_stat_t;

    // Matrix row combined with row 3 for each plane
    function automatic logic [1:0] src_row(input logic [2:0] plane);
        return plane[2:1];
    endfunction

    // Planes built as row 3 minus the source row
    function automatic logic src_neg(input logic [2:0] plane);
        logic neg;
        case (plane)
            3'd1, 3'd2, 3'd5: neg = 1'b1;
            default:          neg = 1'b0;
        endcase
        return neg;
    endfunction

endpackage

`default_nettype wire

[rtl/vfc_sqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none

module vfc_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [vfc_pkg::SQ_W-1:0]  radicand,
    output logic                      busy,
    output logic [vfc_pkg::ROOT_W-1:0] root
);
    import vfc_pkg::*;

    logic                busy_reg;
    logic [4:0]          cnt_reg;
    logic [SQ_W-1:0]     rad_reg;
    logic [ROOT_W+2:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W+2:0]   rem_t;
    logic [ROOT_W+2:0]   trial;

    assign rem_t = {rem_reg[ROOT_W:0], rad_reg[SQ_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd31;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            if (rem_t >= trial)
            begin
                rem_reg  <= rem_t - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_t;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[rtl/vfc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module vfc_div #(
    parameter int DVD_W = 49
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [DVD_W-1:0]           dividend,
    input  logic [vfc_pkg::ROOT_W-1:0] divisor,
    output logic                       busy,
    output logic [DVD_W-1:0]           quot
);
    import vfc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DVD_W-1:0]  quot_reg;
    logic [ROOT_W-1:0] div_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W:0]   rem_t;
    logic [ROOT_W:0]   rem_sub;

    assign rem_t   = {rem_reg, quot_reg[DVD_W-1]};
    assign rem_sub = rem_t - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_LAST;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quot_reg <= dividend;
            div_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_t >= {1'b0, div_reg})
            begin
                rem_reg  <= rem_sub[ROOT_W-1:0];
                quot_reg <= {quot_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_t[ROOT_W-1:0];
                quot_reg <= {quot_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

[rtl/vfc_datapath.sv]
// Datapath: matrix rows, plane store, dot-product unit, normalization and result register.
`default_nettype none

module vfc_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vfc_pkg::vfc_cmd_t               cmd,
    output vfc_pkg::vfc_stat_t              stat,
    input  logic [vfc_pkg::TDATA_IN_W-1:0]  in_data,
    input  logic [vfc_pkg::TUSER_W-1:0]     in_user,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [vfc_pkg::TDATA_OUT_W-1:0] out_data
);
    import vfc_pkg::*;

    localparam int DVD_W = MAG_W + FRAC_BITS;

    logic [2:0]                op_reg;
    logic [1:0]                row_reg;
    logic signed [DATA_W-1:0]  val_reg   [4];
    logic signed [OPD_W-1:0]   opa_reg   [3];
    logic signed [OPD_W-1:0]   opb_reg   [3];
    logic signed [DATA_W-1:0]  row3_reg  [4];
    logic signed [DATA_W-1:0]  rows_reg  [3][4];
    logic signed [DATA_W-1:0]  plane_mem [24];
    logic [MAG_W-1:0]          mag_reg   [4];
    logic                      neg_reg   [4];
    logic signed [PROD_W-1:0]  prod_a_reg;
    logic signed [PROD_W-1:0]  prod_b_reg;
    logic signed [ACC_W-1:0]   acc_a_reg;
    logic signed [ACC_W-1:0]   acc_b_reg;
    logic [1:0]                cont_reg;
    logic                      vis_reg;
    logic                      out_valid_reg;
    logic [1:0]                out_cont_reg;
    logic                      out_vis_reg;

    logic signed [DATA_W-1:0]  in_v [4];
    logic signed [DATA_W-1:0]  in_e [3];
    logic [MAG_W-1:0]          raw_mag [4];
    logic                      raw_neg [4];
    logic                      raw_big;
    logic [1:0]                sr;
    logic                      sn;
    logic signed [DATA_W-1:0]  coef;
    logic signed [ACC_W-1:0]   c_sh;
    logic signed [ACC_W-1:0]   pa;
    logic signed [ACC_W-1:0]   pb;
    logic signed [ACC_W-1:0]   pb_abs;
    logic signed [ACC_W-1:0]   rad_sh;
    logic signed [ACC_W-1:0]   vis_sum;
    logic signed [OPD_W-1:0]   mx;
    logic signed [OPD_W-1:0]   mya;
    logic signed [OPD_W-1:0]   myb;
    logic                      sqrt_busy;
    logic                      div_busy;
    logic [ROOT_W-1:0]         root;
    logic [DVD_W-1:0]          quot;
    logic                      q_hi;
    logic [DATA_W-1:0]         pw_val;

    // Input item fields
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            in_v[i] = in_data[2 + DATA_W*i +: DATA_W];
        for (int i = 0; i < 3; i++)
            in_e[i] = in_data[2 + DATA_W*(4 + i) +: DATA_W];
    end

    // Raw plane magnitudes, halved when a normal component reaches 2^31
    always_comb
    begin
        logic signed [MAG_W-1:0] a33;
        logic signed [MAG_W-1:0] b33;
        logic signed [MAG_W-1:0] raw;
        sr = src_row(cmd.plane);
        sn = src_neg(cmd.plane);
        for (int c = 0; c < 4; c++)
        begin
            a33 = MAG_W'(row3_reg[c]);
            b33 = MAG_W'(rows_reg[sr][c]);
            raw = sn ? (a33 - b33) : (a33 + b33);
            raw_neg[c] = raw[MAG_W-1];
            raw_mag[c] = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
        end
        raw_big = (|raw_mag[0][MAG_W-1:MAG_W-2]) | (|raw_mag[1][MAG_W-1:MAG_W-2])
                | (|raw_mag[2][MAG_W-1:MAG_W-2]);
    end

    // Shared multiplier operands
    always_comb
    begin
        coef   = plane_mem[{cmd.plane, cmd.axis}];
        c_sh   = ACC_W'(coef) <<< FRAC_BITS;
        mx     = cmd.sq_mul ? $signed(mag_reg[cmd.axis]) : OPD_W'(coef);
        mya    = cmd.sq_mul ? $signed(mag_reg[cmd.axis]) : opa_reg[cmd.axis];
        myb    = opb_reg[cmd.axis];
        pa     = ACC_W'(prod_a_reg);
        pb     = ACC_W'(prod_b_reg);
        pb_abs = pb[ACC_W-1] ? -pb : pb;
        rad_sh = ACC_W'(val_reg[3]) <<< FRAC_BITS;
        vis_sum = acc_a_reg + acc_b_reg;
    end

    // Normalized coefficient, saturated to 32 bits; zero for a degenerate plane
    always_comb
    begin
        q_hi = |quot[DVD_W-1:DATA_W-1];
        if (root == '0)
            pw_val = '0;
        else if (neg_reg[cmd.axis])
            pw_val = q_hi ? SAT_MIN : (~quot[DATA_W-1:0] + DATA_W'(1));
        else
            pw_val = q_hi ? SAT_MAX : quot[DATA_W-1:0];
    end

    vfc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.sqrt_go),
        .radicand (acc_a_reg[SQ_W-1:0]),
        .busy     (sqrt_busy),
        .root     (root)
    );

    vfc_div #(.DVD_W(DVD_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend ({mag_reg[cmd.axis], {FRAC_BITS{1'b0}}}),
        .divisor  (root),
        .busy     (div_busy),
        .quot     (quot)
    );

    // Item capture, matrix rows, magnitudes, products and accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_user;
            row_reg <= in_data[1:0];
            for (int i = 0; i < 4; i++)
                val_reg[i] <= in_v[i];
            for (int i = 0; i < 3; i++)
            begin
                if (in_user == OP_VISIBLE)
                begin
                    opa_reg[i] <= OPD_W'(in_v[i]) + OPD_W'(in_e[i]);
                    opb_reg[i] <= OPD_W'(in_e[i]) - OPD_W'(in_v[i]);
                end
                else
                begin
                    opa_reg[i] <= OPD_W'(in_v[i]);
                    opb_reg[i] <= OPD_W'(in_e[i]);
                end
            end
        end
        if (cmd.row_wr)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (row_reg == ROW_LAST)
                    row3_reg[c] <= val_reg[c];
                else
                    rows_reg[row_reg][c] <= val_reg[c];
            end
        end
        if (cmd.raw)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mag_reg[c] <= raw_big ? (raw_mag[c] >> 1) : raw_mag[c];
                neg_reg[c] <= raw_neg[c];
            end
        end
        if (cmd.sq_mul || cmd.q_mul)
        begin
            prod_a_reg <= mx * mya;
            prod_b_reg <= mx * myb;
        end
        if (cmd.acc_clr)
        begin
            acc_a_reg <= '0;
            acc_b_reg <= '0;
        end
        else if (cmd.const_ld)
        begin
            acc_a_reg <= (op_reg == OP_VISIBLE) ? (c_sh <<< 1) : c_sh;
            acc_b_reg <= (op_reg == OP_BOX) ? c_sh : '0;
        end
        else if (cmd.acc_add)
        begin
            case (op_reg)
                OP_LOAD, OP_POINT, OP_SPHERE:
                begin
                    acc_a_reg <= acc_a_reg + pa;
                end
                OP_BOX:
                begin
                    acc_a_reg <= acc_a_reg + ((pa > pb) ? pa : pb);
                    acc_b_reg <= acc_b_reg + ((pa > pb) ? pb : pa);
                end
                OP_VISIBLE:
                begin
                    acc_a_reg <= acc_a_reg + pa;
                    acc_b_reg <= acc_b_reg + pb_abs;
                end
                default:
                begin
                    acc_a_reg <= acc_a_reg;
                end
            endcase
        end
    end

    // Plane store resets to zero planes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 24; i++)
                plane_mem[i] <= '0;
        end
        else if (cmd.plane_wr)
        begin
            plane_mem[{cmd.plane, cmd.axis}] <= pw_val;
        end
    end

    // Per-query verdict and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_reg      <= CONT_INSIDE;
            vis_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
            out_cont_reg  <= CONT_INSIDE;
            out_vis_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.q_init)
            begin
                cont_reg <= CONT_INSIDE;
                vis_reg  <= 1'b1;
            end
            else if (cmd.q_eval)
            begin
                case (op_reg)
                    OP_POINT:
                    begin
                        if (cont_reg != CONT_OUTSIDE && acc_a_reg < 0)
                            cont_reg <= CONT_OUTSIDE;
                    end
                    OP_SPHERE:
                    begin
                        if (cont_reg != CONT_OUTSIDE)
                        begin
                            if (acc_a_reg < -rad_sh)
                                cont_reg <= CONT_OUTSIDE;
                            else if (acc_a_reg < rad_sh)
                                cont_reg <= CONT_ISECT;
                        end
                    end
                    OP_BOX:
                    begin
                        if (cont_reg != CONT_OUTSIDE)
                        begin
                            if (acc_a_reg < 0)
                                cont_reg <= CONT_OUTSIDE;
                            else if (acc_b_reg < 0)
                                cont_reg <= CONT_ISECT;
                        end
                    end
                    OP_VISIBLE:
                    begin
                        if (vis_sum < 0)
                            vis_reg <= 1'b0;
                    end
                    default:
                    begin
                        vis_reg <= vis_reg;
                    end
                endcase
            end

            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg == OP_VISIBLE)
                begin
                    out_cont_reg <= CONT_INSIDE;
                    out_vis_reg  <= vis_reg;
                end
                else
                begin
                    out_cont_reg <= cont_reg;
                    out_vis_reg  <= (cont_reg != CONT_OUTSIDE);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op        = op_reg;
    assign stat.row       = row_reg;
    assign stat.sqrt_busy = sqrt_busy;
    assign stat.div_busy  = div_busy;
    assign stat.out_full  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = {5'b0, out_vis_reg, out_cont_reg};

endmodule

`default_nettype wire

[rtl/vfc_ctrl.sv]
// Controller: sequences plane extraction after a load of row 3 and the six-plane walk of a query.
`default_nettype none

module vfc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vfc_pkg::vfc_stat_t stat,
    output vfc_pkg::vfc_cmd_t  cmd
);
    import vfc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_QCONST,
        S_QMUL,
        S_QACC,
        S_QEVAL,
        S_PUSH,
        S_XRAW,
        S_XSQ,
        S_XSQACC,
        S_XSQRT,
        S_XSQW,
        S_XDIV,
        S_XDIVW,
        S_XWR
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] plane_reg, plane_next;
    logic [1:0] axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.plane  = plane_reg;
        cmd.axis   = axis_reg;
        in_ready   = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                plane_next = '0;
                case (stat.op)
                    OP_LOAD:
                    begin
                        cmd.row_wr = 1'b1;
                        state_next = (stat.row == ROW_LAST) ? S_XRAW : S_IDLE;
                    end
                    OP_POINT, OP_SPHERE, OP_BOX, OP_VISIBLE:
                    begin
                        cmd.q_init = 1'b1;
                        state_next = S_QCONST;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_QCONST:
            begin
                cmd.axis     = AXIS_CONST;
                cmd.const_ld = 1'b1;
                axis_next    = '0;
                state_next   = S_QMUL;
            end
            S_QMUL:
            begin
                cmd.q_mul   = 1'b1;
                cmd.acc_add = (axis_reg != 2'd0);
                if (axis_reg == AXIS_Z)
                    state_next = S_QACC;
                else
                    axis_next = axis_reg + 2'd1;
            end
            S_QACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_QEVAL;
            end
            S_QEVAL:
            begin
                cmd.q_eval = 1'b1;
                if (plane_reg == PLANE_LAST)
                    state_next = S_PUSH;
                else
                begin
                    plane_next = plane_reg + 3'd1;
                    state_next = S_QCONST;
                end
            end
            S_PUSH:
            begin
                if (!stat.out_full)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_XRAW:
            begin
                cmd.raw     = 1'b1;
                cmd.acc_clr = 1'b1;
                axis_next   = '0;
                state_next  = S_XSQ;
            end
            S_XSQ:
            begin
                cmd.sq_mul  = 1'b1;
                cmd.acc_add = (axis_reg != 2'd0);
                if (axis_reg == AXIS_Z)
                    state_next = S_XSQACC;
                else
                    axis_next = axis_reg + 2'd1;
            end
            S_XSQACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_XSQRT;
            end
            S_XSQRT:
            begin
                cmd.sqrt_go = 1'b1;
                state_next  = S_XSQW;
            end
            S_XSQW:
            begin
                if (!stat.sqrt_busy)
                begin
                    axis_next  = '0;
                    state_next = S_XDIV;
                end
            end
            S_XDIV:
            begin
                cmd.div_go = 1'b1;
                state_next = S_XDIVW;
            end
            S_XDIVW:
            begin
                if (!stat.div_busy)
                    state_next = S_XWR;
            end
            S_XWR:
            begin
                cmd.plane_wr = 1'b1;
                if (axis_reg == AXIS_CONST)
                begin
                    if (plane_reg == PLANE_LAST)
                        state_next = S_IDLE;
                    else
                    begin
                        plane_next = plane_reg + 3'd1;
                        state_next = S_XRAW;
                    end
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_XDIV;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            plane_reg <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

`default_nettype wire

[rtl/view_frustum_culling.sv]
// Top level of the view frustum culling block: controller, datapath and checks.
//
//  channel  | direction | tuser           | tdata
//  ---------+-----------+-----------------+--------------------------------------------
//  s_axis   | in        | operation [2:0] | row_index, value_x/y/z/w, extent_x/y/z
//  m_axis   | out       | -               | containment, visible (zero padded)
//
// A query request walks the six planes one at a time through one shared pair
// of 33x33 multipliers. A load request of row 3 re-extracts and normalizes
// all six planes with the bit-serial square root and divider. Other load
// requests only store their matrix row. Reset clears the plane store to zero
// planes (point, box and visibility queries then answer inside and visible;
// a sphere of positive radius answers intersecting); matrix rows hold
// whatever was last loaded.
// A result waiting in the output register does not stop the next request from
// being taken; only a second result stalls until the first one is taken.
`default_nettype none

module view_frustum_culling #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // row_index[1:0], value_x, value_y, value_z, value_w, extent_x, extent_y,
    // extent_z (32 bits each, signed Q), zero pad to 232 bits
    input  logic [vfc_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // operation[2:0]
    input  logic [vfc_pkg::TUSER_W-1:0]     s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // containment[1:0], visible[2], zero pad to 8 bits
    output logic [vfc_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
    import vfc_pkg::*;

    vfc_cmd_t  cmd;
    vfc_stat_t stat;

    // Sequence requests: capture, dispatch, walk planes or rebuild them
    vfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold matrix, planes, arithmetic and the result register
    vfc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // Never overwrite a result that is still waiting
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.out_full)
        else $error("result pushed over a pending result");

    // Start the iterative units only when they are free
    a_units_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sqrt_go || cmd.div_go) |-> (!stat.sqrt_busy && !stat.div_busy))
        else $error("iterative unit started while busy");

    // Take a new request only with no normalization in flight
    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!stat.sqrt_busy && !stat.div_busy))
        else $error("request taken during plane normalization");

    // A result appears only after the controller pushed it
    a_valid_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.push))
        else $error("result valid without a push");

endmodule

`default_nettype wire
